// File: hdl/bsfr_pkg.sv
`default_nettype none
package bsfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int EV_W      = 3;
    localparam int CNT_W     = 9;
    localparam int MAC_W     = 48;
    localparam int FCNT_W    = 16;
    localparam int CFG_AW    = 3;
    localparam int MAC_BYTES = 6;

    // result payload: byte, reply, update, peer, pending, dropped
    localparam int OUT_PAY_W  = BYTE_W + 1 + 1 + MAC_W + CNT_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] FLIP = 8'h20;

    localparam logic [MODE_W-1:0] MODE_LINE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DROP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_DATA_RDY  = 3'd1;
    localparam logic [EV_W-1:0] EV_TEXT      = 3'd2;
    localparam logic [EV_W-1:0] EV_LOST      = 3'd3;
    localparam logic [EV_W-1:0] EV_READ      = 3'd4;
    localparam logic [EV_W-1:0] EV_READ_ERR  = 3'd5;
    localparam logic [EV_W-1:0] EV_DROPPED   = 3'd6;
    localparam logic [EV_W-1:0] EV_HELLO_END = 3'd7;

    localparam logic [CFG_AW-1:0] CFG_DELIM = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ESC   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TEXT  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HELLO = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_REPLY = 3'd4;

    localparam logic [BYTE_W-1:0] RST_DELIM = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESC   = 8'd125;
    localparam logic [BYTE_W-1:0] RST_TEXT  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_HELLO = 8'd2;
    localparam logic [BYTE_W-1:0] RST_REPLY = 8'd3;

    typedef struct packed {
        logic take;       // item accepted this cycle
        logic rd_done;    // buffer read data is ready for the result
        logic mac_shift;  // shift one address byte in
        logic mac_issue;  // issue the next address byte read
        logic mac_done;   // last address byte shifted in
    } t_cmd;

    typedef struct packed {
        logic need_rd;    // item waits for one buffer read
        logic need_mac;   // item loads the peer address
        logic fill_ok;    // fill level within the buffer depth
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/bsfr_ram.sv
`default_nettype none
module bsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_q
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: hdl/bsfr_ctrl.sv
`default_nettype none
module bsfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bsfr_pkg::t_cmd     o_cmd,
    input  wire bsfr_pkg::t_sts i_sts
);
    import bsfr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;

    localparam int MAC_CW = $clog2(MAC_BYTES);
    localparam logic [MAC_CW-1:0] MAC_LAST = MAC_CW'(MAC_BYTES - 1);

    logic [1:0]        r_state, n_state;
    logic [MAC_CW-1:0] r_cnt, n_cnt;
    logic              r_ovalid, n_ovalid;
    logic              take;
    logic              load;
    logic              mac_last;

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;
    assign mac_last   = (r_state == S_MAC) && (r_cnt == MAC_LAST);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_sts.need_rd) begin
                        n_state = S_READ;
                    end else if (i_sts.need_mac) begin
                        n_state = S_MAC;
                        n_cnt   = '0;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            S_READ: begin
                load    = 1'b1;
                n_state = S_IDLE;
            end
            S_MAC: begin
                n_cnt = r_cnt + 1'b1;
                if (mac_last) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_cmd.take      = take;
    assign o_cmd.rd_done   = (r_state == S_READ);
    assign o_cmd.mac_shift = (r_state == S_MAC);
    assign o_cmd.mac_issue = (r_state == S_MAC) && !mac_last;
    assign o_cmd.mac_done  = mac_last;

endmodule
`default_nettype wire

// File: hdl/bsfr_dpath.sv
`default_nettype none
module bsfr_dpath #(
    parameter int BUFFER_DEPTH = bsfr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bsfr_pkg::t_cmd                  i_cmd,
    output bsfr_pkg::t_sts                       o_sts,
    input  wire logic [bsfr_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]     i_line_byte,
    input  wire logic                            i_cfg_we,
    input  wire logic [bsfr_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]     i_cfg_wdata,
    output logic      [bsfr_pkg::EV_W-1:0]       o_event,
    output logic      [bsfr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                                 o_reply,
    output logic                                 o_peer_upd,
    output logic      [bsfr_pkg::MAC_W-1:0]      o_peer,
    output logic      [bsfr_pkg::CNT_W-1:0]      o_pend,
    output logic      [bsfr_pkg::CNT_W-1:0]      o_dropped,
    output logic                                 o_ram_we,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_ram_waddr,
    output logic      [bsfr_pkg::BYTE_W-1:0]     o_ram_wdata,
    output logic                                 o_ram_re,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_ram_raddr,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]     i_ram_q
);
    import bsfr_pkg::*;

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int IW   = AW + 1;
    localparam int IW1  = IW + 1;
    localparam int SPAN = 2 * BUFFER_DEPTH;
    localparam int CW   = (IW > CNT_W) ? IW : CNT_W;

    localparam logic [1:0] P_WAIT  = 2'd0;
    localparam logic [1:0] P_FRAME = 2'd1;
    localparam logic [1:0] P_ESC   = 2'd2;

    localparam logic [1:0] K_DATA  = 2'd0;
    localparam logic [1:0] K_TEXT  = 2'd1;
    localparam logic [1:0] K_HELLO = 2'd2;
    localparam logic [1:0] K_REPLY = 2'd3;

    localparam logic [FCNT_W-1:0] FCNT_MAX = '1;

    // configuration
    logic [BYTE_W-1:0] r_delim, r_esc, r_text, r_hello, r_rcode;

    // frame and buffer state
    logic [1:0]        r_pst, n_pst;
    logic [1:0]        r_kind, n_kind;
    logic [FCNT_W-1:0] r_fcnt, n_fcnt;
    logic              r_acc, n_acc;
    logic [CNT_W-1:0]  r_pend, n_pend;
    logic [IW-1:0]     r_wi, n_wi;
    logic [IW-1:0]     r_ri, n_ri;
    logic [MAC_W-1:0]  r_peer, n_peer;

    // result fields
    logic [EV_W-1:0]   r_ev, n_ev;
    logic [BYTE_W-1:0] r_ob, n_ob;
    logic              r_rep, n_rep;
    logic              r_upd, n_upd;
    logic [CNT_W-1:0]  r_drop, n_drop;

    logic [IW-1:0]     fill;
    logic [IW-1:0]     wi_inc, ri_inc;
    logic [CW-1:0]     pend_x, fill_x, drop_x;
    logic [IW1-1:0]    ri_sum;
    logic              tb;
    logic [BYTE_W-1:0] tb_c;
    logic              need_rd, need_mac;
    logic              re_take;
    logic              we;

    always_comb begin
        fill = r_wi - r_ri;
        if (r_wi < r_ri) begin
            fill = r_wi - r_ri + IW'(SPAN);
        end
        wi_inc = (r_wi == IW'(SPAN - 1)) ? '0 : r_wi + 1'b1;
        ri_inc = (r_ri == IW'(SPAN - 1)) ? '0 : r_ri + 1'b1;
        pend_x = CW'(r_pend);
        fill_x = CW'(fill);
        drop_x = (pend_x < fill_x) ? pend_x : fill_x;
        ri_sum = IW1'(r_ri) + IW1'(drop_x);
        if (ri_sum >= IW1'(SPAN)) begin
            ri_sum = ri_sum - IW1'(SPAN);
        end
    end

    always_comb begin
        n_pst    = r_pst;
        n_kind   = r_kind;
        n_fcnt   = r_fcnt;
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_wi     = r_wi;
        n_ri     = r_ri;
        n_peer   = r_peer;
        n_ev     = r_ev;
        n_ob     = r_ob;
        n_rep    = r_rep;
        n_upd    = r_upd;
        n_drop   = r_drop;
        tb       = 1'b0;
        tb_c     = i_line_byte;
        need_rd  = 1'b0;
        need_mac = 1'b0;
        re_take  = 1'b0;
        we       = 1'b0;

        // decode of the item, applied only when it is taken
        if (i_cmd.take) begin
            n_ev   = EV_NONE;
            n_ob   = '0;
            n_rep  = 1'b0;
            n_upd  = 1'b0;
            n_drop = '0;
            unique case (i_mode)
                MODE_LINE: begin
                    unique case (r_pst)
                        P_WAIT: begin
                            if (i_line_byte == r_delim) begin
                                n_kind = K_DATA;
                                n_fcnt = '0;
                                n_acc  = (r_pend == '0);
                                n_pst  = P_FRAME;
                            end
                        end
                        P_FRAME: begin
                            if (i_line_byte == r_esc) begin
                                n_pst = P_ESC;
                            end else if (i_line_byte == r_delim) begin
                                if (r_fcnt != '0) begin
                                    if (r_kind == K_DATA) begin
                                        n_pend = r_fcnt[CNT_W-1:0];
                                        n_ev   = EV_DATA_RDY;
                                    end else if (r_kind == K_HELLO || r_kind == K_REPLY) begin
                                        n_ev  = EV_HELLO_END;
                                        n_rep = (r_kind == K_HELLO);
                                        if (r_fcnt == FCNT_W'(MAC_BYTES)
                                                && fill >= IW'(MAC_BYTES)) begin
                                            // start pulling the address bytes
                                            need_mac = 1'b1;
                                            re_take  = 1'b1;
                                            n_ri     = ri_inc;
                                        end
                                    end
                                    n_pst  = P_WAIT;
                                    n_kind = K_DATA;
                                    n_fcnt = '0;
                                    n_acc  = 1'b1;
                                end
                            end else begin
                                tb = 1'b1;
                            end
                        end
                        P_ESC: begin
                            n_pst = P_FRAME;
                            if (i_line_byte == (r_delim ^ FLIP)) begin
                                tb   = 1'b1;
                                tb_c = r_delim;
                            end else if (i_line_byte == (r_esc ^ FLIP)) begin
                                tb   = 1'b1;
                                tb_c = r_esc;
                            end else if (i_line_byte == (r_text ^ FLIP)) begin
                                n_kind = K_TEXT;
                            end else if (i_line_byte == (r_hello ^ FLIP)) begin
                                n_kind = K_HELLO;
                            end else if (i_line_byte == (r_rcode ^ FLIP)) begin
                                n_kind = K_REPLY;
                            end
                        end
                        default: begin
                            n_pst = P_WAIT;
                        end
                    endcase

                    // one payload byte
                    if (tb) begin
                        if (r_kind == K_TEXT) begin
                            if (r_fcnt != FCNT_MAX) begin
                                n_fcnt = r_fcnt + 1'b1;
                            end
                            n_ob = tb_c;
                            n_ev = EV_TEXT;
                        end else if (r_acc) begin
                            // full buffer: drop the byte silently
                            if (fill < IW'(BUFFER_DEPTH)) begin
                                we   = 1'b1;
                                n_wi = wi_inc;
                                if (r_fcnt != FCNT_MAX) begin
                                    n_fcnt = r_fcnt + 1'b1;
                                end
                            end
                        end else begin
                            n_wi   = '0;
                            n_ri   = '0;
                            n_pst  = P_WAIT;
                            n_kind = K_DATA;
                            n_fcnt = '0;
                            n_acc  = 1'b1;
                            n_ev   = EV_LOST;
                        end
                    end
                end
                MODE_READ: begin
                    n_ev = EV_READ_ERR;
                    if (r_pend != '0) begin
                        if (fill == '0) begin
                            n_pend = '0;
                        end else begin
                            need_rd = 1'b1;
                            re_take = 1'b1;
                            n_ri    = ri_inc;
                            n_pend  = r_pend - 1'b1;
                            n_ev    = EV_READ;
                        end
                    end
                end
                MODE_DROP: begin
                    n_drop = CNT_W'(drop_x);
                    n_ri   = ri_sum[IW-1:0];
                    n_pend = '0;
                    n_ev   = EV_DROPPED;
                end
                MODE_NOP: begin
                    n_ev = EV_NONE;
                end
                default: begin
                    n_ev = EV_NONE;
                end
            endcase
        end

        if (i_cmd.rd_done) begin
            n_ob = i_ram_q;
        end
        if (i_cmd.mac_shift) begin
            n_peer = {r_peer[MAC_W-BYTE_W-1:0], i_ram_q};
        end
        if (i_cmd.mac_issue) begin
            n_ri = ri_inc;
        end
        if (i_cmd.mac_done) begin
            n_upd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= RST_DELIM;
            r_esc   <= RST_ESC;
            r_text  <= RST_TEXT;
            r_hello <= RST_HELLO;
            r_rcode <= RST_REPLY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DELIM: r_delim <= i_cfg_wdata;
                CFG_ESC:   r_esc   <= i_cfg_wdata;
                CFG_TEXT:  r_text  <= i_cfg_wdata;
                CFG_HELLO: r_hello <= i_cfg_wdata;
                CFG_REPLY: r_rcode <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pst  <= P_WAIT;
            r_kind <= K_DATA;
            r_fcnt <= '0;
            r_acc  <= 1'b1;
            r_pend <= '0;
            r_wi   <= '0;
            r_ri   <= '0;
            r_peer <= '0;
        end else begin
            r_pst  <= n_pst;
            r_kind <= n_kind;
            r_fcnt <= n_fcnt;
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_wi   <= n_wi;
            r_ri   <= n_ri;
            r_peer <= n_peer;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev   <= n_ev;
        r_ob   <= n_ob;
        r_rep  <= n_rep;
        r_upd  <= n_upd;
        r_drop <= n_drop;
    end

    assign o_sts.need_rd  = need_rd;
    assign o_sts.need_mac = need_mac;
    assign o_sts.fill_ok  = (fill <= IW'(BUFFER_DEPTH));

    assign o_event    = r_ev;
    assign o_out_byte = r_ob;
    assign o_reply    = r_rep;
    assign o_peer_upd = r_upd;
    assign o_peer     = r_peer;
    assign o_pend     = r_pend;
    assign o_dropped  = r_drop;

    always_comb begin
        o_ram_waddr = AW'(r_wi);
        if (r_wi >= IW'(BUFFER_DEPTH)) begin
            o_ram_waddr = AW'(r_wi - IW'(BUFFER_DEPTH));
        end
        o_ram_raddr = AW'(r_ri);
        if (r_ri >= IW'(BUFFER_DEPTH)) begin
            o_ram_raddr = AW'(r_ri - IW'(BUFFER_DEPTH));
        end
    end

    assign o_ram_we    = we;
    assign o_ram_wdata = tb_c;
    assign o_ram_re    = re_take || i_cmd.mac_issue;

endmodule
`default_nettype wire

// File: hdl/byte_stuffed_frame_receiver.sv
// A result is registered in the cycle after its item is accepted; a buffer read
// passes through the read state, and a hello end that loads the peer address
// through the address state (six sequential reads, single buffer read port).
// Throughput: one item per cycle otherwise; ready is low during a read or address
// load, or while a result waits to be taken. Reset (synchronous, active low) clears
// all control state and restores the configuration defaults; buffer contents stay.
`default_nettype none
module byte_stuffed_frame_receiver #(
    parameter int BUFFER_DEPTH = bsfr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]       i_s_axis_tdata,  // line_byte
    input  wire logic [bsfr_pkg::MODE_W-1:0]       i_s_axis_tuser,  // mode
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // out_byte, reply_request, peer_updated, peer_address, pending_length,
    // dropped_count, zero fill
    output logic      [bsfr_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic      [bsfr_pkg::EV_W-1:0]         o_m_axis_tuser,  // event_res
    input  wire logic                              i_cfg_we,
    input  wire logic [bsfr_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]       i_cfg_wdata
);
    import bsfr_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int PAD = OUT_DATA_W - OUT_PAY_W;

    t_cmd              cmd;
    t_sts              sts;
    logic [EV_W-1:0]   ev;
    logic [BYTE_W-1:0] ob;
    logic              rep;
    logic              upd;
    logic [MAC_W-1:0]  peer;
    logic [CNT_W-1:0]  pend;
    logic [CNT_W-1:0]  drop;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_q;

    bsfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bsfr_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_s_axis_tuser),
        .i_line_byte (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_event     (ev),
        .o_out_byte  (ob),
        .o_reply     (rep),
        .o_peer_upd  (upd),
        .o_peer      (peer),
        .o_pend      (pend),
        .o_dropped   (drop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_q     (ram_q)
    );

    bsfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_q     (ram_q)
    );

    assign o_m_axis_tdata = {{PAD{1'b0}}, drop, pend, peer, upd, rep, ob};
    assign o_m_axis_tuser = ev;

    // ring fill level never exceeds the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.fill_ok)
        else $error("ring fill level above buffer depth");

    // an address update only comes with a hello end
    a_upd_hello: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && upd) |-> (ev == EV_HELLO_END))
        else $error("peer update without hello end");

    // a byte is carried only by text and read results
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ev != EV_TEXT && ev != EV_READ) |-> (ob == '0))
        else $error("out byte set on a result that carries none");

    // a dropped count only comes with a drop result
    a_drop_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && drop != '0) |-> (ev == EV_DROPPED))
        else $error("dropped count on a non-drop result");

    // a read result leaves the pending count one lower
    a_read_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.take && sts.need_rd) |=> (pend == $past(pend) - 1'b1))
        else $error("pending count not advanced on read");

endmodule
`default_nettype wire
